>>> rtl/sat3_pkg.sv
package sat3_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_SET  = 2'd1,
		CMD_EVAL = 2'd2,
		CMD_FLIP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLIP_CL,
		ST_FLIP_VAR,
		ST_SCAN,
		ST_RESP
	} state_t;

	localparam logic REG_CLAUSE_COUNT = 1'b0;
	localparam logic REG_MAX_FLIPS    = 1'b1;

	localparam logic [12:0] CLAUSE_COUNT_RST = 13'd4096;
	localparam logic [13:0] MAX_FLIPS_RST    = 14'd3072;

	localparam logic [1:0] CHOICE_A = 2'd0;
	localparam logic [1:0] CHOICE_B = 2'd1;

	typedef struct packed {
		logic       neg;
		logic [9:0] vidx;
	} lit_t;

	typedef struct packed {
		lit_t c;
		lit_t b;
		lit_t a;
	} clause_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] clause_slot;
		logic [9:0]  lit_a_var;
		logic        lit_a_neg;
		logic [9:0]  lit_b_var;
		logic        lit_b_neg;
		logic [9:0]  lit_c_var;
		logic        lit_c_neg;
		logic [9:0]  var_slot;
		logic        var_value;
		logic [1:0]  literal_choice;
	} item_t;

	typedef struct packed {
		logic [11:0] unsat_clause;
		logic        all_satisfied;
		logic        budget_exhausted;
		logic [13:0] flips_done;
	} result_t;

endpackage

>>> rtl/sat3_clause_mem.sv
module sat3_clause_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  sat3_pkg::clause_t wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output sat3_pkg::clause_t rdata
);

	sat3_pkg::clause_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/sat3_var_mem.sv
module sat3_var_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic                wdata,
	input  logic                re,
	input  logic [2:0][AW-1:0]  raddr,
	output logic [2:0]          rdata
);

	// one copy per read port, all written together
	logic bank_q [3][DEPTH];

	always_ff @(posedge clk) begin
		for (int p = 0; p < 3; p++) begin
			if (we) begin
				bank_q[p][waddr] <= wdata;
			end
			if (re) begin
				rdata[p] <= bank_q[p][raddr[p]];
			end
		end
	end

endmodule

>>> rtl/sat3_random_walk_step.sv
// Random-walk 3-SAT step engine. Clauses and variables live in on-chip
// memories loaded through start commands; evaluate scans clauses from slot 0
// one per cycle through a three-stage memory pipeline (clause read, then three
// variable reads, then the clause test) and stops at the first unsatisfied
// clause. Load, set and a flip that cannot act give their result in the cycle
// after accept. Evaluate and flip scan L = min(clause_count, NUM_CLAUSES)
// clauses. A flip that acts first reads its clause, then reads the chosen
// variable and writes it back inverted, ahead of its scan. One item is in
// flight at a time: busy is high from accept until the result. The result
// shows on result for the single cycle that done is high; the receiver
// cannot stall it, so it must take the beat in that cycle.
module sat3_random_walk_step #(
	parameter int NUM_VARS    = 1024,
	parameter int NUM_CLAUSES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sat3_pkg::item_t   item,
	output logic              done,
	output sat3_pkg::result_t result,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [13:0]       wr_data
);

	localparam int CAW = $clog2(NUM_CLAUSES);
	localparam int VAW = $clog2(NUM_VARS);

	sat3_pkg::state_t state_q, state_d;

	logic [12:0] clause_count_q;
	logic [13:0] max_flips_q;
	logic [11:0] unsat_q;
	logic        sat_q;
	logic [13:0] flips_q;
	logic [1:0]  choice_q;
	logic [12:0] iss_q;

	logic        s1_vld_q;
	logic [11:0] s1_idx_q;
	logic        s2_vld_q;
	logic [11:0] s2_idx_q;
	logic [2:0]  s2_neg_q;
	logic [2:0]  s2_inr_q;

	logic [VAW-1:0] fvar_addr_q;
	logic           fvar_inr_q;

	sat3_pkg::clause_t cl_wdata, cl_rdata;
	logic              cl_we, cl_re;
	logic [CAW-1:0]    cl_waddr, cl_raddr;

	logic               vm_we, vm_wdata, vm_re;
	logic [VAW-1:0]     vm_waddr;
	logic [2:0][VAW-1:0] vm_raddr;
	logic [2:0]         vm_rdata;

	logic [31:0] slot_ext, iss_ext, unsat_ext, vslot_ext;
	logic [2:0][31:0] lit_ext;
	logic [2:0]       lit_inr;
	logic [31:0] fsel_ext;
	logic [9:0]  fsel_vidx;

	logic        accept, issue, found, scan_end, flip_ok, slot_inr, vslot_inr;
	logic        start_scan, clr_flips, inc_flips, rec_unsat, rec_sat;
	logic [12:0] scan_len;
	logic [2:0]  lit_true;

	assign accept    = start && (state_q == sat3_pkg::ST_IDLE);
	assign busy      = (state_q != sat3_pkg::ST_IDLE);
	assign scan_len  = (32'(clause_count_q) < NUM_CLAUSES) ? clause_count_q
	                                                       : 13'(NUM_CLAUSES);
	assign flip_ok   = !sat_q && (flips_q < max_flips_q);

	assign slot_ext  = 32'(item.clause_slot);
	assign vslot_ext = 32'(item.var_slot);
	assign iss_ext   = 32'(iss_q);
	assign unsat_ext = 32'(unsat_q);
	assign slot_inr  = slot_ext < NUM_CLAUSES;
	assign vslot_inr = vslot_ext < NUM_VARS;

	assign lit_ext[0] = 32'(cl_rdata.a.vidx);
	assign lit_ext[1] = 32'(cl_rdata.b.vidx);
	assign lit_ext[2] = 32'(cl_rdata.c.vidx);
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lit_inr[k] = lit_ext[k] < NUM_VARS;
		end
	end

	always_comb begin
		unique case (choice_q)
			sat3_pkg::CHOICE_A: fsel_vidx = cl_rdata.a.vidx;
			sat3_pkg::CHOICE_B: fsel_vidx = cl_rdata.b.vidx;
			default:            fsel_vidx = cl_rdata.c.vidx;
		endcase
	end
	assign fsel_ext = 32'(fsel_vidx);

	// a variable outside the store reads as zero
	assign lit_true = (s2_inr_q & vm_rdata) ^ s2_neg_q;
	assign issue    = (state_q == sat3_pkg::ST_SCAN) && (iss_q < scan_len) && !found;
	assign found    = (state_q == sat3_pkg::ST_SCAN) && s2_vld_q && (lit_true == 3'b000);
	assign scan_end = (state_q == sat3_pkg::ST_SCAN) && (iss_q >= scan_len)
	                  && !s1_vld_q && !s2_vld_q;

	always_comb begin
		state_d    = state_q;
		start_scan = 1'b0;
		clr_flips  = 1'b0;
		inc_flips  = 1'b0;
		rec_unsat  = 1'b0;
		rec_sat    = 1'b0;
		cl_we      = 1'b0;
		cl_re      = 1'b0;
		cl_raddr   = iss_ext[CAW-1:0];
		vm_we      = 1'b0;
		vm_wdata   = item.var_value;
		vm_waddr   = vslot_ext[VAW-1:0];
		vm_re      = 1'b0;
		vm_raddr[0] = lit_ext[0][VAW-1:0];
		vm_raddr[1] = lit_ext[1][VAW-1:0];
		vm_raddr[2] = lit_ext[2][VAW-1:0];
		done       = 1'b0;
		unique case (state_q)
			sat3_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (item.cmd)
						sat3_pkg::CMD_LOAD: begin
							cl_we   = slot_inr;
							state_d = sat3_pkg::ST_RESP;
						end
						sat3_pkg::CMD_SET: begin
							vm_we   = vslot_inr;
							state_d = sat3_pkg::ST_RESP;
						end
						sat3_pkg::CMD_EVAL: begin
							clr_flips  = 1'b1;
							start_scan = 1'b1;
							state_d    = sat3_pkg::ST_SCAN;
						end
						sat3_pkg::CMD_FLIP: begin
							if (flip_ok) begin
								cl_re    = 1'b1;
								cl_raddr = unsat_ext[CAW-1:0];
								state_d  = sat3_pkg::ST_FLIP_CL;
							end else begin
								state_d = sat3_pkg::ST_RESP;
							end
						end
					endcase
				end
			end
			sat3_pkg::ST_FLIP_CL: begin
				vm_re       = 1'b1;
				vm_raddr[0] = fsel_ext[VAW-1:0];
				state_d     = sat3_pkg::ST_FLIP_VAR;
			end
			sat3_pkg::ST_FLIP_VAR: begin
				vm_we      = fvar_inr_q;
				vm_waddr   = fvar_addr_q;
				vm_wdata   = ~vm_rdata[0];
				inc_flips  = 1'b1;
				start_scan = 1'b1;
				state_d    = sat3_pkg::ST_SCAN;
			end
			sat3_pkg::ST_SCAN: begin
				cl_re = issue;
				vm_re = s1_vld_q;
				if (found) begin
					rec_unsat = 1'b1;
					state_d   = sat3_pkg::ST_RESP;
				end else if (scan_end) begin
					rec_sat = 1'b1;
					state_d = sat3_pkg::ST_RESP;
				end
			end
			sat3_pkg::ST_RESP: begin
				done    = 1'b1;
				state_d = sat3_pkg::ST_IDLE;
			end
			default: state_d = sat3_pkg::ST_IDLE;
		endcase
	end

	assign cl_waddr = slot_ext[CAW-1:0];
	assign cl_wdata = '{
		c: '{neg: item.lit_c_neg, vidx: item.lit_c_var},
		b: '{neg: item.lit_b_neg, vidx: item.lit_b_var},
		a: '{neg: item.lit_a_neg, vidx: item.lit_a_var}
	};

	sat3_clause_mem #(
		.DEPTH(NUM_CLAUSES),
		.AW   (CAW)
	) u_clause_mem (
		.clk  (clk),
		.we   (cl_we),
		.waddr(cl_waddr),
		.wdata(cl_wdata),
		.re   (cl_re),
		.raddr(cl_raddr),
		.rdata(cl_rdata)
	);

	sat3_var_mem #(
		.DEPTH(NUM_VARS),
		.AW   (VAW)
	) u_var_mem (
		.clk  (clk),
		.we   (vm_we),
		.waddr(vm_waddr),
		.wdata(vm_wdata),
		.re   (vm_re),
		.raddr(vm_raddr),
		.rdata(vm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sat3_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clause_count_q <= sat3_pkg::CLAUSE_COUNT_RST;
			max_flips_q    <= sat3_pkg::MAX_FLIPS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				sat3_pkg::REG_CLAUSE_COUNT: clause_count_q <= wr_data[12:0];
				sat3_pkg::REG_MAX_FLIPS:    max_flips_q    <= wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unsat_q  <= '0;
			sat_q    <= 1'b0;
			flips_q  <= '0;
			iss_q    <= '0;
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
		end else begin
			if (clr_flips) begin
				flips_q <= '0;
			end else if (inc_flips) begin
				flips_q <= flips_q + 14'd1;
			end
			if (rec_unsat) begin
				unsat_q <= s2_idx_q;
				sat_q   <= 1'b0;
			end else if (rec_sat) begin
				unsat_q <= '0;
				sat_q   <= 1'b1;
			end
			if (start_scan) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 13'd1;
			end
			s1_vld_q <= issue;
			s2_vld_q <= s1_vld_q && !found && (state_q == sat3_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			choice_q <= item.literal_choice;
		end
		if (state_q == sat3_pkg::ST_FLIP_CL) begin
			fvar_addr_q <= fsel_ext[VAW-1:0];
			fvar_inr_q  <= fsel_ext < NUM_VARS;
		end
		s1_idx_q <= iss_q[11:0];
		s2_idx_q <= s1_idx_q;
		s2_neg_q <= {cl_rdata.c.neg, cl_rdata.b.neg, cl_rdata.a.neg};
		s2_inr_q <= lit_inr;
	end

	assign result = '{
		unsat_clause:     unsat_q,
		all_satisfied:    sat_q,
		budget_exhausted: flips_q >= max_flips_q,
		flips_done:       flips_q
	};

endmodule

>>> rtl/sat3_rws_chk.sv
module sat3_rws_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input sat3_pkg::result_t result
);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat outside a busy command");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result beat for a command");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_sat_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.all_satisfied) |-> (result.unsat_clause == 12'd0))
		else $error("all satisfied with nonzero clause index");

endmodule

bind sat3_random_walk_step sat3_rws_chk u_sat3_rws_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
